// ===== rtl/core/mtbd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtbd_pkg
// shared types and constants of the median threshold bitmap level block
// ----------------------------------------------------------------------------
package mtbd_pkg;

  localparam int PIX_W     = 8;
  localparam int SIZE_W    = 13;
  localparam int ROW_W     = 12;
  localparam int PAIR_W    = 9;
  localparam int CFG_IDX_W = 2;

  localparam int HEIGHT_LIMIT = 4096;
  localparam int BAND         = 4;
  localparam int TOP_MEDIAN   = 251;
  localparam int PIX_MAX      = 255;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MEDIAN = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_t;

  // position of the current pixel as decoded by the scan counters
  typedef struct packed {
    logic in_block;   // pixel belongs to a full 2x2 block
    logic odd_col;
    logic odd_row;
    logic frame_end;  // last pixel of the level image
  } scan_pos_t;

endpackage : mtbd_pkg
`default_nettype wire

// ===== rtl/core/mtbd_line_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtbd_line_mem
// line store of even-row pair sums, one write and one registered read port
// ----------------------------------------------------------------------------
module mtbd_line_mem #(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11,
  parameter int DATA_W = 9
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : mtbd_line_mem
`default_nettype wire

// ===== rtl/core/mtbd_scan.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtbd_scan
// column and row counters with block position and end-of-image decode
// ----------------------------------------------------------------------------
module mtbd_scan #(
  parameter int MAX_WIDTH = 4096,
  parameter int COL_W     = 12,
  parameter int ADDR_W    = 11
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       advance,
  input  wire logic [mtbd_pkg::SIZE_W-1:0] image_width,
  input  wire logic [mtbd_pkg::SIZE_W-1:0] image_height,
  output      mtbd_pkg::scan_pos_t        pos,
  output      logic [ADDR_W-1:0]          pair_index
);
  import mtbd_pkg::*;

  localparam int CMP_W = ((COL_W > SIZE_W) ? COL_W : SIZE_W) + 1;

  logic [COL_W-1:0] column_count, column_count_next;
  logic [ROW_W-1:0] row_count, row_count_next;
  logic [CMP_W-1:0] width_eff, height_eff, width_ext, height_ext;
  logic             in_col, in_row, row_end;

  // effective geometry, out-of-range sizes clamped
  always_comb begin
    width_ext  = CMP_W'(image_width);
    height_ext = CMP_W'(image_height);
    if (width_ext == '0) begin
      width_eff = CMP_W'(1);
    end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
      width_eff = CMP_W'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    if (height_ext == '0) begin
      height_eff = CMP_W'(1);
    end else if (height_ext > CMP_W'(HEIGHT_LIMIT)) begin
      height_eff = CMP_W'(HEIGHT_LIMIT);
    end else begin
      height_eff = height_ext;
    end
  end

  always_comb begin
    in_col  = CMP_W'({column_count[COL_W-1:1], 1'b1}) < width_eff;
    in_row  = CMP_W'({row_count[ROW_W-1:1], 1'b1}) < height_eff;
    row_end = (CMP_W'(column_count) + CMP_W'(1)) >= width_eff;

    pos.in_block  = in_col && in_row;
    pos.odd_col   = column_count[0];
    pos.odd_row   = row_count[0];
    pos.frame_end = row_end && ((CMP_W'(row_count) + CMP_W'(1)) >= height_eff);

    pair_index = column_count[ADDR_W:1];

    if (row_end) begin
      column_count_next = '0;
      row_count_next    = pos.frame_end ? '0 : row_count + ROW_W'(1);
    end else begin
      column_count_next = column_count + COL_W'(1);
      row_count_next    = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (advance) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule : mtbd_scan
`default_nettype wire

// ===== rtl/core/median_threshold_bitmap_downsample.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// median_threshold_bitmap_downsample
// one pyramid level of a median threshold bitmap with 2x2 downsampling
// ----------------------------------------------------------------------------
// Gray pixels enter in raster order, one item per clock when both sides
// keep up. Every pixel leaves as one result item, via the stage 1 and output
// registers, with its mono bit (above median+4), its exclusion bit (outside
// median -/+ 4, both bounds clamped to the pixel range) and, on the pixel
// closing a 2x2 block (odd row, odd column), the half-size pixel sum>>2.
// Pixels in a trailing odd column or row give all-zero bits and no half-size
// pixel. frame_last marks the final pixel of the image, after which the
// counters wrap to the top left. The line store has one write port for the
// even-row pair sums and one registered read port for the odd row below,
// enough for one pixel per clock. Write and read of one entry are a full
// row apart, so no forwarding is needed. The line store has no reset and
// needs no clearing pass. Configuration registers are written through the
// cfg port, which is always ready, and must only change while idle.
// ----------------------------------------------------------------------------
module median_threshold_bitmap_downsample #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration write channel
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [mtbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mtbd_pkg::SIZE_W-1:0]    cfg_data,
  // pixel input channel
  input  wire logic                          pixel_valid,
  output      logic                          pixel_ready,
  input  wire logic [mtbd_pkg::PIX_W-1:0]     gray_pixel,
  // result channel
  output      logic                          result_valid,
  input  wire logic                          result_ready,
  output      logic                          mono_bit,
  output      logic                          exclude_bit,
  output      logic                          small_valid,
  output      logic [mtbd_pkg::PIX_W-1:0]     small_pixel,
  output      logic                          frame_last
);
  import mtbd_pkg::*;

  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int COL_W      = $clog2(MAX_WIDTH);

  // configuration registers
  logic [PIX_W-1:0]  median_level;
  logic [SIZE_W-1:0] image_width;
  logic [SIZE_W-1:0] image_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      median_level <= PIX_W'(128);
      image_width  <= SIZE_W'(640);
      image_height <= SIZE_W'(480);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MEDIAN: median_level <= cfg_data[PIX_W-1:0];
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        default: ;  // unused index, write ignored
      endcase
    end
  end

  // handshake: stage 1 moves on when the output register is free or taken
  logic s1_valid;
  logic s1_advance;
  logic accept;

  assign s1_advance  = !result_valid || result_ready;
  assign pixel_ready = !s1_valid || s1_advance;
  assign accept      = pixel_valid && pixel_ready;

  // stage 0: position decode
  scan_pos_t         pos;
  logic [ADDR_W-1:0] pair_index;

  mtbd_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W),
    .ADDR_W    (ADDR_W)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .advance      (accept),
    .image_width  (image_width),
    .image_height (image_height),
    .pos          (pos),
    .pair_index   (pair_index)
  );

  // band bounds, clamped at both ends of the pixel range
  logic [PIX_W-1:0] lower_bound, upper_bound;
  logic             above_band, below_band;

  always_comb begin
    lower_bound = (median_level <= PIX_W'(BAND)) ? '0 : median_level - PIX_W'(BAND);
    upper_bound = (median_level >= PIX_W'(TOP_MEDIAN)) ? PIX_W'(PIX_MAX)
                                                       : median_level + PIX_W'(BAND);
    above_band  = gray_pixel > upper_bound;
    below_band  = gray_pixel < lower_bound;
  end

  // held left pixel of the current horizontal pair
  logic [PIX_W-1:0]  held_left_pixel;
  logic [PAIR_W-1:0] pair_sum;

  assign pair_sum = PAIR_W'(held_left_pixel) + PAIR_W'(gray_pixel);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_left_pixel <= '0;
    end else if (accept && pos.in_block && !pos.odd_col) begin
      held_left_pixel <= gray_pixel;
    end
  end

  // line store: even rows write the pair sum, odd rows read it back
  logic              line_wr, line_rd;
  logic [PAIR_W-1:0] line_rd_data;

  assign line_wr = accept && pos.in_block && pos.odd_col && !pos.odd_row;
  assign line_rd = accept && pos.in_block && pos.odd_col && pos.odd_row;

  mtbd_line_mem #(
    .DEPTH  (LINE_DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (PAIR_W)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (line_wr),
    .wr_addr (pair_index),
    .wr_data (pair_sum),
    .rd_en   (line_rd),
    .rd_addr (pair_index),
    .rd_data (line_rd_data)
  );

  // stage 1: classification bits and partial block sum wait for the read
  logic              s1_mono, s1_excl, s1_block, s1_last;
  logic [PAIR_W-1:0] s1_pair;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel_ready) begin
      s1_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mono  <= pos.in_block && above_band;
      s1_excl  <= pos.in_block && (above_band || below_band);
      s1_block <= line_rd;
      s1_last  <= pos.frame_end;
      s1_pair  <= pair_sum;
    end
  end

  // block sum of the four pixels, mean by shift
  logic [PAIR_W:0] block_sum;

  assign block_sum = (PAIR_W + 1)'(line_rd_data) + (PAIR_W + 1)'(s1_pair);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_advance) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid) begin
      mono_bit    <= s1_mono;
      exclude_bit <= s1_excl;
      small_valid <= s1_block;
      small_pixel <= s1_block ? block_sum[PAIR_W:2] : '0;
      frame_last  <= s1_last;
    end
  end

endmodule : median_threshold_bitmap_downsample
`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the median threshold bitmap level block
// ----------------------------------------------------------------------------
// Streams gray pixels through the block under random idling on both sides.
// An internal model of the scan counters, the held left pixel and the line
// of pair sums works out the bits and the half-size pixel of every accepted
// item. Each result is checked field by field against it in order.
// ----------------------------------------------------------------------------
module tb_top;
  import mtbd_pkg::*;

  localparam int LINE_W        = 4096;
  localparam int SETTLE        = 6;       // block latency plus margin
  localparam int HOLD_CYCLES   = 120;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_TARGET = 850;
  localparam int TAIL_ITEMS    = 100;
  localparam int PRINT_CAP     = 40;
  localparam int SIZE_MAX      = (1 << SIZE_W) - 1;

  // index with no register behind it, writes must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic              mono;
    logic              excl;
    logic              blk_valid;
    logic [PIX_W-1:0]  blk_pix;
    logic              last;
    int unsigned       seq;
  } bitmap_result_t;

  // dut signals, all inputs known from time zero
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MEDIAN;
  logic [SIZE_W-1:0]    cfg_data = '0;
  logic                 pixel_valid = 1'b0;
  logic                 pixel_ready;
  logic [PIX_W-1:0]     gray_pixel = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  logic                 mono_bit;
  logic                 exclude_bit;
  logic                 small_valid;
  logic [PIX_W-1:0]     small_pixel;
  logic                 frame_last;

  // model of the block: configuration and scan state
  logic [PIX_W-1:0]     band_median = 8'd128;
  logic [SIZE_W-1:0]    geo_width = 13'd640;
  logic [SIZE_W-1:0]    geo_height = 13'd480;
  int unsigned          scan_col = 0;
  int unsigned          scan_row = 0;
  logic [PIX_W-1:0]     left_pix = '0;
  logic [PAIR_W-1:0]    pair_line [(LINE_W + 1) / 2];

  // traffic
  logic [PIX_W-1:0]     gray_backlog[$];
  bitmap_result_t       bitmap_expected[$];
  int unsigned          items_queued = 0;
  int unsigned          pixels_accepted = 0;
  int unsigned          reg_writes = 0;
  int unsigned          frames_seen = 0;
  int unsigned          blocks_seen = 0;
  int unsigned          input_stalls = 0;
  int unsigned          error_count = 0;
  int unsigned          cycle_count = 0;

  // idling controls
  logic                 send_idle = 1'b1;
  logic                 recv_idle = 1'b1;
  logic                 steady = 1'b0;     // no idling at all in the closing part
  int                   send_gap = 0;
  int                   recv_gap = 0;
  logic                 hold_request = 1'b0;
  logic                 hold_used = 1'b0;
  int                   hold_left = 0;

  median_threshold_bitmap_downsample #(
    .MAX_WIDTH(LINE_W)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .gray_pixel  (gray_pixel),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .mono_bit    (mono_bit),
    .exclude_bit (exclude_bit),
    .small_valid (small_valid),
    .small_pixel (small_pixel),
    .frame_last  (frame_last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // geometry as the block sees it, out-of-range sizes folded back in
  function automatic int unsigned effective_width();
    if (geo_width == 0) return 1;
    if (geo_width > LINE_W) return LINE_W;
    return geo_width;
  endfunction

  function automatic int unsigned effective_height();
    if (geo_height == 0) return 1;
    if (geo_height > HEIGHT_LIMIT) return HEIGHT_LIMIT;
    return geo_height;
  endfunction

  // classify one pixel, update the scan state and queue what the block owes
  task automatic predict_bitmap_pixel(input logic [PIX_W-1:0] pix);
    bitmap_result_t r;
    int unsigned    w, h, lower, upper, idx, sum;
    logic           in_col, in_row, row_end, frame_end;
    w = effective_width();
    h = effective_height();
    lower = (band_median <= BAND) ? 0 : band_median - BAND;
    upper = (band_median >= TOP_MEDIAN) ? PIX_MAX : band_median + BAND;
    in_col = (scan_col | 1) < w;
    in_row = (scan_row | 1) < h;
    row_end = (scan_col + 1 >= w);
    frame_end = row_end && (scan_row + 1 >= h);
    r = '{mono: 1'b0, excl: 1'b0, blk_valid: 1'b0, blk_pix: '0, last: frame_end,
          seq: pixels_accepted};
    if (in_col && in_row) begin
      idx = scan_col >> 1;
      r.mono = (pix > upper);
      r.excl = (pix > upper) || (pix < lower);
      if (scan_col % 2 == 0) begin
        left_pix = pix;
      end else if (scan_row % 2 == 0) begin
        pair_line[idx] = PAIR_W'(left_pix) + PAIR_W'(pix);
      end else begin
        sum = pair_line[idx] + left_pix + pix;
        r.blk_valid = 1'b1;
        r.blk_pix = PIX_W'(sum >> 2);
      end
    end
    if (row_end) begin
      scan_col = 0;
      scan_row = frame_end ? 0 : scan_row + 1;
    end else begin
      scan_col = scan_col + 1;
    end
    bitmap_expected.push_back(r);
    pixels_accepted++;
  endtask

  // a geometry change must never lead to a pair sum being read before written:
  // only on an even row, and mid-row only when that row has been storing pairs
  function automatic bit geometry_change_safe();
    return (scan_row % 2 == 0) && (scan_col == 0 || (scan_row | 1) < effective_height());
  endfunction

  function automatic int unsigned pick_median();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return BAND;
      2: return BAND + 1;
      3: return TOP_MEDIAN - 1;
      4: return TOP_MEDIAN;
      5: return PIX_MAX;
      default: return $urandom_range(0, PIX_MAX);
    endcase
  endfunction

  function automatic int unsigned pick_width();
    case ($urandom_range(0, 19))
      0: return 0;
      1: return 1;
      2: return LINE_W;
      3: return $urandom_range(LINE_W + 1, SIZE_MAX);
      4: return 2;
      default: return $urandom_range(2, 14);
    endcase
  endfunction

  function automatic int unsigned pick_height();
    case ($urandom_range(0, 19))
      0: return 0;
      1: return 1;
      2: return HEIGHT_LIMIT;
      3: return $urandom_range(HEIGHT_LIMIT + 1, SIZE_MAX);
      default: return $urandom_range(2, 9);
    endcase
  endfunction

  // mostly close to the band edges, with the extremes and a spread
  function automatic logic [PIX_W-1:0] pick_gray();
    int v;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return PIX_W'(PIX_MAX);
      2, 3, 4: return PIX_W'($urandom_range(0, PIX_MAX));
      default: begin
        v = int'(band_median) + int'($urandom_range(0, 12)) - 6;
        if (v < 0) v = 0;
        if (v > PIX_MAX) v = PIX_MAX;
        return PIX_W'(v);
      end
    endcase
  endfunction

  task automatic queue_gray(input logic [PIX_W-1:0] v);
    gray_backlog.push_back(v);
    items_queued++;
  endtask

  // wait for the block to drain, then let the pipeline settle
  task automatic wait_idle();
    while (gray_backlog.size() != 0 || pixel_valid || bitmap_expected.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes need no drop; caller lowers it
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= SIZE_W'(value);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MEDIAN: band_median = PIX_W'(value);
      REG_WIDTH:  geo_width = SIZE_W'(value);
      REG_HEIGHT: geo_height = SIZE_W'(value);
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic report_mismatch(input string what, input int unsigned seq,
                                 input int unsigned got, input int unsigned want);
    if (error_count < PRINT_CAP)
      $display("pixel %0d: %s got %0d want %0d", seq, what, got, want);
    error_count++;
  endtask

  // pixel sender: holds the item until taken, idles in random bursts
  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (pixel_valid && pixel_ready) predict_bitmap_pixel(gray_pixel);
      if (pixel_valid && !pixel_ready) input_stalls++;
      if (!pixel_valid || pixel_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          pixel_valid <= 1'b0;
        end else if (gray_backlog.size() != 0 && send_idle && !steady &&
                     $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(0, 13);
          pixel_valid <= 1'b0;
        end else if (gray_backlog.size() != 0) begin
          pixel_valid <= 1'b1;
          gray_pixel <= gray_backlog.pop_front();
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted on its own
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  // result receiver and checker
  always @(posedge clk) begin
    bitmap_result_t want;
    if (rst) begin
      result_ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (result_valid && result_ready) begin
        if (bitmap_expected.size() == 0) begin
          report_mismatch("result with no pixel pending", pixels_accepted, 1, 0);
        end else begin
          want = bitmap_expected.pop_front();
          if (mono_bit !== want.mono)
            report_mismatch("mono_bit", want.seq, mono_bit, want.mono);
          if (exclude_bit !== want.excl)
            report_mismatch("exclude_bit", want.seq, exclude_bit, want.excl);
          if (small_valid !== want.blk_valid)
            report_mismatch("small_valid", want.seq, small_valid, want.blk_valid);
          if (small_pixel !== want.blk_pix)
            report_mismatch("small_pixel", want.seq, small_pixel, want.blk_pix);
          if (frame_last !== want.last)
            report_mismatch("frame_last", want.seq, frame_last, want.last);
          if (want.last) frames_seen++;
          if (want.blk_valid) blocks_seen++;
        end
      end
      if (hold_left != 0) begin
        result_ready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        result_ready <= 1'b0;
      end else if (recv_idle && !steady && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(0, 13);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed out with %0d results outstanding", bitmap_expected.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned n, w, h;
    bit          hold_done;
    hold_done = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset configuration, 128 gives the band 124..132, both edges hit
    queue_gray(8'd123); queue_gray(8'd124); queue_gray(8'd132); queue_gray(8'd133);
    wait_idle();

    // oversized geometry folds to the line limit, band clamped at zero
    write_register(REG_MEDIAN, BAND);
    write_register(REG_WIDTH, SIZE_MAX);
    write_register(REG_HEIGHT, SIZE_MAX);
    cfg_valid <= 1'b0;
    queue_gray(8'd0); queue_gray(8'd9);
    wait_idle();

    // shrink mid-row: the row finishes at the new width, keeping the pair
    // stored before the change, then the odd row closes two blocks and the
    // image; the spare index must change nothing
    write_register(REG_WIDTH, 4);
    write_register(REG_HEIGHT, 2);
    write_register(REG_SPARE, SIZE_MAX);
    cfg_valid <= 1'b0;
    queue_gray(8'd8);
    queue_gray(8'd3); queue_gray(8'd4); queue_gray(8'd9); queue_gray(8'd255);
    queue_gray(8'd7);
    wait_idle();

    // odd width and height, top band clamped to full scale
    write_register(REG_MEDIAN, TOP_MEDIAN);
    write_register(REG_WIDTH, 3);
    write_register(REG_HEIGHT, 3);
    cfg_valid <= 1'b0;
    queue_gray(8'd246); queue_gray(8'd247); queue_gray(8'd255);
    queue_gray(8'd255); queue_gray(8'd254); queue_gray(8'd0);
    queue_gray(8'd1);   queue_gray(8'd2);   queue_gray(8'd3);
    wait_idle();

    // zero width acts as one column: every pixel trailing, one per row
    write_register(REG_MEDIAN, PIX_MAX);
    write_register(REG_WIDTH, 0);
    cfg_valid <= 1'b0;
    queue_gray(8'd250); queue_gray(8'd251); queue_gray(8'd255);

    // random phases, each started from a drained block
    while (items_queued < RANDOM_TARGET) begin
      wait_idle();
      send_idle <= ($urandom_range(0, 3) != 0);
      recv_idle <= ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1) != 0)
        write_register(REG_MEDIAN, pick_median() | ($urandom_range(0, 31) << PIX_W));
      if ((scan_col == 0 && scan_row == 0 && $urandom_range(0, 2) != 0) ||
          (geometry_change_safe() && $urandom_range(0, 3) == 0)) begin
        w = pick_width();
        h = pick_height();
        // a full-length trailing row would only stream zeros for ages
        if (w >= LINE_W && h < 2) h = 2;
        write_register(REG_WIDTH, w);
        write_register(REG_HEIGHT, h);
      end
      cfg_valid <= 1'b0;
      if (!hold_done && items_queued >= 400) begin
        // receiver stops for a long stretch while the sender keeps pushing
        hold_done = 1'b1;
        hold_request <= 1'b1;
        send_idle <= 1'b0;
        n = 160;
      end else begin
        n = $urandom_range(6, 60);
      end
      repeat (n) queue_gray(pick_gray());
    end

    // closing stretch at full rate on both sides
    wait_idle();
    steady <= 1'b1;
    repeat (TAIL_ITEMS) queue_gray(pick_gray());
    wait_idle();

    $display("%0d pixels checked over %0d register writes", pixels_accepted, reg_writes);
    $display("%0d frames ended, %0d 2x2 blocks pooled, %0d cycles of input back-pressure",
             frames_seen, blocks_seen, input_stalls);
    if (error_count == 0 && bitmap_expected.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
